>>> src/obrb_pkg.sv
package obrb_pkg;

   localparam int KIND_W = 2;
   localparam int BYTE_W = 8;
   localparam int FILL_W = 6;

   localparam logic [KIND_W-1:0] KIND_WRITE = 2'd0;
   localparam logic [KIND_W-1:0] KIND_READ  = 2'd1;
   localparam logic [KIND_W-1:0] KIND_DUMP  = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_READ = 3'b010,
      ST_DUMP = 3'b100
   } seq_state_type;

   typedef struct packed {
      logic [BYTE_W-1:0] byte_out;
      logic              has_data;
      logic              is_last;
   } rsp_data_type;

endpackage

>>> src/obrb_ram.sv
module obrb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> src/overwriting_byte_ring_buffer.sv
// Byte ring buffer that overwrites its oldest byte when written while full.
// Request channel (req_*): one beat carries a kind and a byte. A write stores
// the byte, a read pops the oldest byte, a dump streams all held bytes oldest
// first without removing them. Unused kind codes are taken and dropped.
// Response channel (rsp_*): every beat reports the byte (if any), the fill
// count after the operation, full, empty, and is_last on the final beat of
// a request. A write, or a read or dump of an empty buffer, gives one status
// beat in the cycle after acceptance. A read of held data first reads the
// byte from the registered read of the byte store, then loads it into the
// output register. A dump streams one byte per cycle while rsp_stall is low,
// from the store's single read port.
// One request is in work at a time; req_stall is high until it has handed
// its last beat to the output register and that register is free. rsp_stall
// holds the output register and pauses the sequencer, never dropping a beat.
// Reset empties the buffer at once; stored bytes are not cleared.
module overwriting_byte_ring_buffer #(
   parameter int DEPTH = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [obrb_pkg::KIND_W-1:0]   req_kind,
   input  logic [obrb_pkg::BYTE_W-1:0]   req_byte_in,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [obrb_pkg::BYTE_W-1:0]   rsp_byte_out,
   output logic                          rsp_has_data,
   output logic [obrb_pkg::FILL_W-1:0]   rsp_fill_count,
   output logic                          rsp_is_full,
   output logic                          rsp_is_empty,
   output logic                          rsp_is_last
);

   import obrb_pkg::*;

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   function automatic logic [PTR_W-1:0] advance(input logic [PTR_W-1:0] p);
      return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   function automatic logic [CNT_W-1:0] held(input logic [PTR_W-1:0] wr,
                                             input logic [PTR_W-1:0] rd,
                                             input logic             full);
      logic [CNT_W-1:0] n;
      if (full) begin
         n = CNT_W'(DEPTH);
      end else if (wr >= rd) begin
         n = CNT_W'(wr - rd);
      end else begin
         n = CNT_W'(DEPTH) - CNT_W'(rd) + CNT_W'(wr);
      end
      return n;
   endfunction

   seq_state_type    state_ff, state_in;
   logic [PTR_W-1:0] wr_pos_ff, wr_pos_in;
   logic [PTR_W-1:0] rd_pos_ff, rd_pos_in;
   logic             full_ff, full_in;
   logic [PTR_W-1:0] dump_pos_ff, dump_pos_in;
   logic [CNT_W-1:0] dump_cnt_ff, dump_cnt_in;

   logic             rsp_valid_ff, rsp_valid_in;
   rsp_data_type     rsp_data_ff, rsp_data_in;
   logic [CNT_W-1:0] rsp_cnt_ff, rsp_cnt_in;
   logic             rsp_full_ff, rsp_full_in;

   logic              out_free;
   logic              req_accept;
   logic              load;
   logic [CNT_W-1:0]  cur_cnt;
   logic              ram_we;
   logic              ram_re;
   logic [PTR_W-1:0]  ram_raddr;
   logic [BYTE_W-1:0] ram_rdata;

   obrb_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (wr_pos_ff),
      .wr_data (req_byte_in),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   // The output register can take a beat when empty or when its beat leaves now.
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign req_stall  = !((state_ff == ST_IDLE) && out_free);
   assign req_accept = req_valid && !req_stall;
   assign cur_cnt    = held(wr_pos_ff, rd_pos_ff, full_ff);

   always_comb begin
      state_in    = state_ff;
      wr_pos_in   = wr_pos_ff;
      rd_pos_in   = rd_pos_ff;
      full_in     = full_ff;
      dump_pos_in = dump_pos_ff;
      dump_cnt_in = dump_cnt_ff;
      ram_we      = 1'b0;
      ram_re      = 1'b0;
      ram_raddr   = rd_pos_ff;
      load        = 1'b0;
      rsp_data_in = rsp_data_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               case (req_kind)
                  KIND_WRITE: begin
                     ram_we      = 1'b1;
                     wr_pos_in   = advance(wr_pos_ff);
                     rd_pos_in   = full_ff ? advance(rd_pos_ff) : rd_pos_ff;
                     full_in     = (wr_pos_in == rd_pos_in);
                     load        = 1'b1;
                     rsp_data_in = '{byte_out: '0, has_data: 1'b0, is_last: 1'b1};
                  end
                  KIND_READ, KIND_DUMP: begin
                     if (cur_cnt == '0) begin
                        load        = 1'b1;
                        rsp_data_in = '{byte_out: '0, has_data: 1'b0, is_last: 1'b1};
                     end else begin
                        ram_re      = 1'b1;
                        dump_pos_in = advance(rd_pos_ff);
                        dump_cnt_in = cur_cnt;
                        state_in    = (req_kind == KIND_READ) ? ST_READ : ST_DUMP;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_READ: begin
            if (out_free) begin
               rd_pos_in   = advance(rd_pos_ff);
               full_in     = 1'b0;
               load        = 1'b1;
               rsp_data_in = '{byte_out: ram_rdata, has_data: 1'b1, is_last: 1'b1};
               state_in    = ST_IDLE;
            end
         end
         ST_DUMP: begin
            if (out_free) begin
               load        = 1'b1;
               rsp_data_in = '{byte_out: ram_rdata, has_data: 1'b1,
                               is_last: (dump_cnt_ff == CNT_W'(1))};
               if (dump_cnt_ff == CNT_W'(1)) begin
                  state_in = ST_IDLE;
               end else begin
                  // Fetch the next byte while this one goes out.
                  ram_re      = 1'b1;
                  ram_raddr   = dump_pos_ff;
                  dump_pos_in = advance(dump_pos_ff);
                  dump_cnt_in = dump_cnt_ff - 1'b1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Status always reflects the buffer after the operation of this beat.
   assign rsp_valid_in = load || (rsp_valid_ff && rsp_stall);
   assign rsp_cnt_in   = held(wr_pos_in, rd_pos_in, full_in);
   assign rsp_full_in  = full_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         wr_pos_ff    <= '0;
         rd_pos_ff    <= '0;
         full_ff      <= 1'b0;
         dump_pos_ff  <= '0;
         dump_cnt_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wr_pos_ff    <= wr_pos_in;
         rd_pos_ff    <= rd_pos_in;
         full_ff      <= full_in;
         dump_pos_ff  <= dump_pos_in;
         dump_cnt_ff  <= dump_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_data_ff <= rsp_data_in;
         rsp_cnt_ff  <= rsp_cnt_in;
         rsp_full_ff <= rsp_full_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_byte_out   = rsp_data_ff.byte_out;
   assign rsp_has_data   = rsp_data_ff.has_data;
   assign rsp_is_last    = rsp_data_ff.is_last;
   assign rsp_fill_count = FILL_W'(rsp_cnt_ff);
   assign rsp_is_full    = rsp_full_ff;
   assign rsp_is_empty   = (rsp_cnt_ff == '0);

endmodule

>>> tb/tb_overwriting_byte_ring_buffer.sv
module tb_overwriting_byte_ring_buffer;
   import obrb_pkg::*;

   localparam int RING_DEPTH = 32;
   localparam int HOLD_CYCLES = 300;
   localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

   typedef struct {
      logic [KIND_W-1:0] kind;
      logic [BYTE_W-1:0] data;
   } ring_op_type;

   typedef struct packed {
      logic [BYTE_W-1:0] byte_out;
      logic              has_data;
      logic [FILL_W-1:0] fill_count;
      logic              is_full;
      logic              is_empty;
      logic              is_last;
   } ring_beat_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   logic [KIND_W-1:0] req_kind = '0;
   logic [BYTE_W-1:0] req_byte_in = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   logic [BYTE_W-1:0] rsp_byte_out;
   logic              rsp_has_data;
   logic [FILL_W-1:0] rsp_fill_count;
   logic              rsp_is_full;
   logic              rsp_is_empty;
   logic              rsp_is_last;

   ring_op_type   op_backlog[$];
   ring_beat_type ring_beats_due[$];

   // Shadow copy of the buffer.
   logic [BYTE_W-1:0] ring_mem [RING_DEPTH];
   int                ring_wr = 0;
   int                ring_rd = 0;
   bit                ring_full = 0;

   event hold_go;
   bit   hold_on = 1'b0;

   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int err_count = 0;
   int ops_taken = 0;
   int beats_seen = 0;
   int overwrites = 0;
   int longest_dump = 0;

   overwriting_byte_ring_buffer #(.DEPTH(RING_DEPTH)) uut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_kind       (req_kind),
      .req_byte_in    (req_byte_in),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_byte_out   (rsp_byte_out),
      .rsp_has_data   (rsp_has_data),
      .rsp_fill_count (rsp_fill_count),
      .rsp_is_full    (rsp_is_full),
      .rsp_is_empty   (rsp_is_empty),
      .rsp_is_last    (rsp_is_last)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   initial begin
      #2000000;
      $display("status: fail");
      $finish;
   end

   function automatic int ring_next(int p);
      return (p + 1) % RING_DEPTH;
   endfunction

   function automatic int ring_held();
      if (ring_full) return RING_DEPTH;
      return (ring_wr - ring_rd + RING_DEPTH) % RING_DEPTH;
   endfunction

   function automatic string beat_text(ring_beat_type b);
      return $sformatf("byte=%h has=%b fill=%0d full=%b empty=%b last=%b",
                       b.byte_out, b.has_data, b.fill_count, b.is_full,
                       b.is_empty, b.is_last);
   endfunction

   task automatic queue_ring_beat(logic [BYTE_W-1:0] val, bit has, bit last);
      ring_beat_type b;
      int            n;
      n = ring_held();
      b.byte_out   = val;
      b.has_data   = has;
      b.fill_count = FILL_W'(n);
      b.is_full    = ring_full;
      b.is_empty   = (n == 0);
      b.is_last    = last;
      ring_beats_due.push_back(b);
   endtask

   task automatic apply_ring_op(logic [KIND_W-1:0] kind, logic [BYTE_W-1:0] data);
      int n;
      int p;
      logic [BYTE_W-1:0] val;
      case (kind)
         KIND_WRITE: begin
            ring_mem[ring_wr] = data;
            if (ring_full) begin
               ring_rd = ring_next(ring_rd);
               overwrites++;
            end
            ring_wr = ring_next(ring_wr);
            ring_full = (ring_wr == ring_rd);
            queue_ring_beat('0, 0, 1);
         end
         KIND_READ: begin
            if (ring_held() == 0) begin
               queue_ring_beat('0, 0, 1);
            end else begin
               val = ring_mem[ring_rd];
               ring_rd = ring_next(ring_rd);
               ring_full = 0;
               queue_ring_beat(val, 1, 1);
            end
         end
         KIND_DUMP: begin
            n = ring_held();
            p = ring_rd;
            if (n == 0) begin
               queue_ring_beat('0, 0, 1);
            end else begin
               if (n > longest_dump) longest_dump = n;
               for (int i = 0; i < n; i++) begin
                  queue_ring_beat(ring_mem[p], 1, i == n - 1);
                  p = ring_next(p);
               end
            end
         end
         default: begin
         end
      endcase
   endtask

   task automatic add_op(logic [KIND_W-1:0] kind, logic [BYTE_W-1:0] data);
      ring_op_type op;
      op.kind = kind;
      op.data = data;
      op_backlog.push_back(op);
   endtask

   task automatic add_random_ops(int count);
      int made;
      int seg;
      int len;
      int pick;
      made = 0;
      while (made < count) begin
         seg = $urandom_range(9);
         if (seg <= 4) begin
            // Bursts of writes push the buffer to full and into overwrite;
            // bursts of reads drain it down to empty.
            len = $urandom_range(40, 1);
            if (len > count - made) len = count - made;
            for (int i = 0; i < len; i++) begin
               if (seg <= 2) add_op(KIND_WRITE, BYTE_W'($urandom_range(255)));
               else add_op(KIND_READ, BYTE_W'($urandom_range(255)));
            end
            made += len;
         end else begin
            pick = $urandom_range(19);
            if (pick < 9) add_op(KIND_WRITE, BYTE_W'($urandom_range(255)));
            else if (pick < 14) add_op(KIND_READ, BYTE_W'($urandom_range(255)));
            else if (pick < 18) add_op(KIND_DUMP, BYTE_W'($urandom_range(255)));
            else add_op(KIND_UNUSED, BYTE_W'($urandom_range(255)));
            if (pick < 18) made++;
         end
      end
   endtask

   task automatic drain_all();
      while (op_backlog.size() != 0 || req_valid || ring_beats_due.size() != 0
             || hold_on)
         @(negedge clock);
      repeat (6) @(negedge clock);
   endtask

   task automatic set_idling(int send_pct, int recv_pct);
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
   endtask

   // The long receiver hold is timed here, apart from the stall driver.
   always begin : long_hold
      @(hold_go);
      hold_on <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      hold_on <= 1'b0;
   end

   always @(posedge clock) begin : drive_requests
      ring_op_type op;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || !req_stall) begin
         if (op_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            op = op_backlog.pop_front();
            req_valid   <= 1'b1;
            req_kind    <= op.kind;
            req_byte_in <= op.data;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if (hold_on) begin
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
      end
   end

   // Output beats are checked before the request taken at the same edge is
   // predicted, so a beat can never be matched against its own request.
   always @(posedge clock) begin : watch_ring
      ring_beat_type got;
      ring_beat_type want;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            got.byte_out   = rsp_byte_out;
            got.has_data   = rsp_has_data;
            got.fill_count = rsp_fill_count;
            got.is_full    = rsp_is_full;
            got.is_empty   = rsp_is_empty;
            got.is_last    = rsp_is_last;
            if (ring_beats_due.size() == 0) begin
               err_count++;
               if (err_count <= 10)
                  $display("unexpected beat %0d: got %s", beats_seen, beat_text(got));
            end else begin
               want = ring_beats_due.pop_front();
               if (got.byte_out !== want.byte_out || got.has_data !== want.has_data
                   || got.fill_count !== want.fill_count
                   || got.is_full !== want.is_full || got.is_empty !== want.is_empty
                   || got.is_last !== want.is_last) begin
                  err_count++;
                  if (err_count <= 10)
                     $display("mismatch on beat %0d: expected %s, got %s",
                              beats_seen, beat_text(want), beat_text(got));
               end
            end
            beats_seen++;
         end
         if (req_valid && !req_stall) begin
            apply_ring_op(req_kind, req_byte_in);
            ops_taken++;
         end
      end
   end

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Empty-buffer cases, ignored kind, extreme bytes, a short dump.
      set_idling(0, 0);
      add_op(KIND_READ, 8'h00);
      add_op(KIND_DUMP, 8'hFF);
      add_op(KIND_UNUSED, 8'h5A);
      add_op(KIND_WRITE, 8'h00);
      add_op(KIND_WRITE, 8'hFF);
      add_op(KIND_WRITE, 8'hA5);
      add_op(KIND_DUMP, 8'h00);
      add_op(KIND_READ, 8'hFF);
      add_op(KIND_READ, 8'h00);
      add_op(KIND_READ, 8'h00);
      add_op(KIND_READ, 8'h00);
      add_op(KIND_DUMP, 8'h00);
      add_op(KIND_WRITE, 8'h3C);
      add_op(KIND_DUMP, 8'h00);
      add_op(KIND_UNUSED, 8'hFF);
      add_op(KIND_UNUSED, 8'h00);
      add_op(KIND_READ, 8'h00);
      drain_all();

      // Long receiver hold while the sender keeps writing: the block backs
      // up, the buffer fills and overwrites, then a full dump, a read, a write and a dump.
      -> hold_go;
      for (int i = 0; i < 40; i++) add_op(KIND_WRITE, BYTE_W'($urandom_range(255)));
      add_op(KIND_DUMP, 8'h00);
      add_op(KIND_READ, 8'h00);
      add_op(KIND_WRITE, 8'h81);
      add_op(KIND_DUMP, 8'h00);
      drain_all();

      set_idling(0, 0);
      add_random_ops(12);
      drain_all();
      set_idling(87, 0);
      add_random_ops(12);
      drain_all();
      set_idling(0, 87);
      add_random_ops(12);
      drain_all();
      set_idling(35, 35);
      add_random_ops(12);
      drain_all();

      $display("Ran %0d requests and checked %0d response beats under four idle mixes",
               ops_taken, beats_seen);
      $display("and a long output hold; %0d overwrites while full, longest dump %0d bytes.",
               overwrites, longest_dump);
      if (err_count == 0) begin
         $display("status: pass");
      end else begin
         $display("%0d mismatches in total", err_count);
         $display("status: fail");
      end
      $finish;
   end

endmodule
